// ----- rtl/msbp_pkg.sv -----
// shared types and constants for the modulus switch and bit pack block
// no dependencies; every rtl file uses it by scoped names
package msbp_pkg;

    localparam int COEF_W     = 64;   // input coefficient width
    localparam int SRC_W      = 63;   // source modulus width
    localparam int TGT_W      = 57;   // target modulus width
    localparam int CNT_W      = 12;   // coefficient count width
    localparam int STEP_W     = 6;    // step counter of the shared unit
    localparam int WID_W      = 6;    // packed width and bit count
    localparam int ACC_W      = 63;   // pack accumulator, 7 leftover + 56 value bits
    localparam int BYTE_W     = 8;
    localparam int LEFT_W     = 7;    // leftover bits kept between words
    localparam int LCNT_W     = 3;    // leftover bit count
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    localparam logic [SRC_W-1:0] SRC_RESET    = 63'd66974689739603969;
    localparam logic [TGT_W-1:0] FIRST_RESET  = 57'd268435456;
    localparam logic [TGT_W-1:0] SECOND_RESET = 57'd1048576;
    localparam logic [CNT_W-1:0] COUNT_RESET  = 12'd2048;
    localparam logic [TGT_W-1:0] TARGET_CAP   = 57'h100000000000000;

    typedef enum logic [1:0] {
        REG_SOURCE = 2'd0,
        REG_FIRST  = 2'd1,
        REG_SECOND = 2'd2,
        REG_COUNT  = 2'd3
    } reg_index_t;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV1  = 9'b000000010,
        S_CMP   = 9'b000000100,
        S_MAG   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_ADDLO = 9'b000100000,
        S_ADDHI = 9'b001000000,
        S_DIV2  = 9'b010000000,
        S_FIX   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic sub;
        logic cin;
    } alu_ctrl_t;

    typedef struct packed {
        logic             start;
        logic             final_item;
        logic [WID_W-1:0] width;
    } pack_cmd_t;

endpackage

// ----- rtl/msbp_alu.sv -----
// shared 64-bit add/subtract unit of the modulus switch datapath
// depends on msbp_pkg for widths and the control struct
module msbp_alu (
    input  logic [msbp_pkg::COEF_W-1:0] a,
    input  logic [msbp_pkg::COEF_W-1:0] b,
    input  msbp_pkg::alu_ctrl_t         ctrl,
    output logic [msbp_pkg::COEF_W-1:0] sum,
    output logic                        carry
);

    logic [msbp_pkg::COEF_W-1:0] b_in;
    logic [msbp_pkg::COEF_W:0]   total;

    // subtract is a + ~b + 1, carry out then means a >= b
    assign b_in  = ctrl.sub ? ~b : b;
    assign total = {1'b0, a} + {1'b0, b_in} + (msbp_pkg::COEF_W + 1)'(ctrl.cin);
    assign sum   = total[msbp_pkg::COEF_W-1:0];
    assign carry = total[msbp_pkg::COEF_W];

endmodule

// ----- rtl/msbp_packer.sv -----
// bit packer: appends one rescaled value to the stream and emits bytes
// through a registered output word; depends on msbp_pkg
module msbp_packer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  msbp_pkg::pack_cmd_t        cmd,
    input  logic [msbp_pkg::TGT_W-1:0] value,
    input  logic                       packed_stall,
    output logic                       packed_valid,
    output logic [msbp_pkg::BYTE_W-1:0] packed_byte,
    output logic                       last_byte,
    output logic                       busy
);

    typedef enum logic [1:0] {
        PK_IDLE = 2'b01,
        PK_EMIT = 2'b10
    } pk_state_t;

    pk_state_t                          state_reg, state_next;
    logic [msbp_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic [msbp_pkg::WID_W-1:0]         nbits_reg, nbits_next;
    logic                               final_reg, final_next;
    logic [msbp_pkg::LEFT_W-1:0]        left_bits_reg, left_bits_next;
    logic [msbp_pkg::LCNT_W-1:0]        left_count_reg, left_count_next;
    logic                               valid_reg, valid_next;
    logic [msbp_pkg::BYTE_W-1:0]        byte_reg, byte_next;
    logic                               last_reg, last_next;
    logic                               slot_free;

    assign slot_free = !valid_reg || !packed_stall;

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        nbits_next      = nbits_reg;
        final_next      = final_reg;
        left_bits_next  = left_bits_reg;
        left_count_next = left_count_reg;
        valid_next      = valid_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        if (valid_reg && !packed_stall)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            PK_IDLE:
            begin
                if (cmd.start)
                begin
                    acc_next   = (msbp_pkg::ACC_W'(value) << left_count_reg)
                               | msbp_pkg::ACC_W'(left_bits_reg);
                    nbits_next = msbp_pkg::WID_W'(left_count_reg) + cmd.width;
                    final_next = cmd.final_item;
                    state_next = PK_EMIT;
                end
            end
            PK_EMIT:
            begin
                if (nbits_reg >= msbp_pkg::WID_W'(msbp_pkg::BYTE_W))
                begin
                    if (slot_free)
                    begin
                        valid_next = 1'b1;
                        byte_next  = acc_reg[msbp_pkg::BYTE_W-1:0];
                        last_next  = final_reg
                                   && (nbits_reg == msbp_pkg::WID_W'(msbp_pkg::BYTE_W));
                        acc_next   = acc_reg >> msbp_pkg::BYTE_W;
                        nbits_next = nbits_reg - msbp_pkg::WID_W'(msbp_pkg::BYTE_W);
                    end
                end
                else if (final_reg && (nbits_reg != '0))
                begin
                    // zero-padded tail byte, upper bits of acc are already clear
                    if (slot_free)
                    begin
                        valid_next = 1'b1;
                        byte_next  = acc_reg[msbp_pkg::BYTE_W-1:0];
                        last_next  = 1'b1;
                        nbits_next = '0;
                    end
                end
                else
                begin
                    if (final_reg)
                    begin
                        left_bits_next  = '0;
                        left_count_next = '0;
                    end
                    else
                    begin
                        left_bits_next  = acc_reg[msbp_pkg::LEFT_W-1:0];
                        left_count_next = nbits_reg[msbp_pkg::LCNT_W-1:0];
                    end
                    state_next = PK_IDLE;
                end
            end
            default:
            begin
                state_next = PK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= PK_IDLE;
            left_bits_reg  <= '0;
            left_count_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            left_bits_reg  <= left_bits_next;
            left_count_reg <= left_count_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        nbits_reg <= nbits_next;
        final_reg <= final_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign packed_valid = valid_reg;
    assign packed_byte  = byte_reg;
    assign last_byte    = last_reg;
    assign busy         = (state_reg == PK_EMIT);

endmodule

// ----- rtl/modulus_switch_bit_pack.sv -----
// modulus switch and bit pack, top level: sequencer, datapath registers, apb registers
// an accepted coefficient goes through one 64-step pass each for the source reduction,
// the scaling multiply and the division, then its value goes to the byte packer
// a new coefficient is taken once the previous one leaves the single shared 64-bit adder
// bytes drain while the next coefficient is in the shared unit; a long output stall holds it
// reset: asynchronous active low, registers to their defaults, stream state to zero
module modulus_switch_bit_pack #(
    parameter int MAX_COEFFS = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // coefficient channel
    input  logic                              coefficient_valid,
    output logic                              coefficient_stall,
    input  logic [msbp_pkg::COEF_W-1:0]       coefficient,
    // packed byte channel
    output logic                              packed_valid,
    input  logic                              packed_stall,
    output logic [msbp_pkg::BYTE_W-1:0]       packed_byte,
    output logic                              last_byte,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msbp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [msbp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [msbp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // item counter spans both rows; SPAN_W holds twice the row length
    localparam int IDX_W  = (MAX_COEFFS > 1) ? $clog2(2 * MAX_COEFFS) : 1;
    localparam int SPAN_W = IDX_W + 1;
    localparam int CMP_W  = (SPAN_W > msbp_pkg::CNT_W) ? SPAN_W : msbp_pkg::CNT_W;

    // ---------------------------------------------------------------
    // configuration registers, 8-byte stride, decoded on paddr[4:3]
    // ---------------------------------------------------------------
    logic [msbp_pkg::SRC_W-1:0] source_modulus_reg;
    logic [msbp_pkg::TGT_W-1:0] first_row_modulus_reg;
    logic [msbp_pkg::TGT_W-1:0] second_row_modulus_reg;
    logic [msbp_pkg::CNT_W-1:0] coefficient_count_reg;
    msbp_pkg::reg_index_t       reg_index;
    logic                       cfg_write;

    assign reg_index = msbp_pkg::reg_index_t'(paddr[msbp_pkg::CFG_ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_modulus_reg     <= msbp_pkg::SRC_RESET;
            first_row_modulus_reg  <= msbp_pkg::FIRST_RESET;
            second_row_modulus_reg <= msbp_pkg::SECOND_RESET;
            coefficient_count_reg  <= msbp_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                msbp_pkg::REG_SOURCE: source_modulus_reg     <= pwdata[msbp_pkg::SRC_W-1:0];
                msbp_pkg::REG_FIRST:  first_row_modulus_reg  <= pwdata[msbp_pkg::TGT_W-1:0];
                msbp_pkg::REG_SECOND: second_row_modulus_reg <= pwdata[msbp_pkg::TGT_W-1:0];
                msbp_pkg::REG_COUNT:  coefficient_count_reg  <= pwdata[msbp_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            msbp_pkg::REG_SOURCE: prdata = msbp_pkg::CFG_DATA_W'(source_modulus_reg);
            msbp_pkg::REG_FIRST:  prdata = msbp_pkg::CFG_DATA_W'(first_row_modulus_reg);
            msbp_pkg::REG_SECOND: prdata = msbp_pkg::CFG_DATA_W'(second_row_modulus_reg);
            msbp_pkg::REG_COUNT:  prdata = msbp_pkg::CFG_DATA_W'(coefficient_count_reg);
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // effective moduli and row bookkeeping
    // ---------------------------------------------------------------
    logic [msbp_pkg::SRC_W-1:0] m_eff;      // source modulus, at least two
    logic [msbp_pkg::SRC_W-1:0] half;       // floor(m/2), the rounding bias
    logic [msbp_pkg::TGT_W-1:0] t_raw;
    logic [msbp_pkg::TGT_W-1:0] t_eff;      // target clamped to [2, 2^56]
    logic [CMP_W-1:0]           row_len;    // coefficients per row, clamped
    logic [CMP_W-1:0]           count_ext;
    logic [CMP_W-1:0]           index_ext;
    logic                       first_row;
    logic                       final_item;

    assign m_eff = (source_modulus_reg[msbp_pkg::SRC_W-1:1] == '0)
                 ? msbp_pkg::SRC_W'(2) : source_modulus_reg;
    assign half  = m_eff >> 1;

    logic [IDX_W-1:0] item_counter_reg, item_counter_next;

    assign count_ext = CMP_W'(coefficient_count_reg);
    assign index_ext = CMP_W'(item_counter_reg);

    always_comb
    begin
        if (count_ext == '0)
        begin
            row_len = CMP_W'(1);
        end
        else if (count_ext > CMP_W'(MAX_COEFFS))
        begin
            row_len = CMP_W'(MAX_COEFFS);
        end
        else
        begin
            row_len = count_ext;
        end
    end

    assign first_row  = index_ext < row_len;
    // final coefficient when index >= 2n-1
    assign final_item = (index_ext + CMP_W'(1)) >= (row_len << 1);
    assign t_raw      = first_row ? first_row_modulus_reg : second_row_modulus_reg;

    always_comb
    begin
        if (t_raw[msbp_pkg::TGT_W-1:1] == '0)
        begin
            t_eff = msbp_pkg::TGT_W'(2);
        end
        else if (t_raw > msbp_pkg::TARGET_CAP)
        begin
            t_eff = msbp_pkg::TARGET_CAP;
        end
        else
        begin
            t_eff = t_raw;
        end
    end

    // ---------------------------------------------------------------
    // sequencer and datapath registers
    //   rem : running remainder of both division passes
    //   lo  : dividend bits out / quotient bits in, multiplier during the multiply
    //   hi  : upper product word
    // ---------------------------------------------------------------
    msbp_pkg::state_t               state_reg, state_next;
    logic [msbp_pkg::STEP_W-1:0]    count_reg, count_next;
    logic [msbp_pkg::COEF_W-1:0]    rem_reg, rem_next;
    logic [msbp_pkg::COEF_W-1:0]    lo_reg, lo_next;
    logic [msbp_pkg::COEF_W-1:0]    hi_reg, hi_next;
    logic [msbp_pkg::SRC_W-1:0]     mag_reg, mag_next;
    logic                           neg_reg, neg_next;
    logic                           carry_reg, carry_next;
    logic [msbp_pkg::TGT_W-1:0]     t_reg, t_next;
    logic                           final_item_reg, final_item_next;
    logic [msbp_pkg::STEP_W-1:0]    top_reg, top_next;     // highest set bit of t
    logic                           ones_reg, ones_next;   // a set bit seen
    logic                           multi_reg, multi_next; // more than one set bit

    logic [msbp_pkg::COEF_W-1:0]    alu_a, alu_b, alu_sum;
    msbp_pkg::alu_ctrl_t            alu_ctrl;
    logic                           alu_carry;
    logic [msbp_pkg::COEF_W-1:0]    rem_shift;

    msbp_pkg::pack_cmd_t            pk_cmd;
    logic [msbp_pkg::TGT_W-1:0]     pk_value;
    logic                           pk_busy;
    logic                           accept;

    assign coefficient_stall = (state_reg != msbp_pkg::S_IDLE);
    assign accept            = coefficient_valid && !coefficient_stall;
    assign rem_shift         = {rem_reg[msbp_pkg::COEF_W-2:0], lo_reg[msbp_pkg::COEF_W-1]};

    // operand select for the shared adder
    always_comb
    begin
        alu_a    = '0;
        alu_b    = '0;
        alu_ctrl = '0;
        case (state_reg)
            msbp_pkg::S_DIV1, msbp_pkg::S_DIV2:
            begin
                // restoring step: shifted remainder minus modulus
                alu_a    = rem_shift;
                alu_b    = msbp_pkg::COEF_W'(m_eff);
                alu_ctrl = '{sub: 1'b1, cin: 1'b1};
            end
            msbp_pkg::S_CMP:
            begin
                // residue against floor(m/2) decides the sign
                alu_a    = rem_reg;
                alu_b    = msbp_pkg::COEF_W'(half);
                alu_ctrl = '{sub: 1'b1, cin: 1'b1};
            end
            msbp_pkg::S_MAG:
            begin
                alu_a    = msbp_pkg::COEF_W'(m_eff);
                alu_b    = rem_reg;
                alu_ctrl = '{sub: 1'b1, cin: 1'b1};
            end
            msbp_pkg::S_MUL:
            begin
                // shift-add, one multiplier bit per step from the bottom of lo
                alu_a = hi_reg;
                alu_b = lo_reg[0] ? msbp_pkg::COEF_W'(mag_reg) : '0;
            end
            msbp_pkg::S_ADDLO:
            begin
                alu_a = lo_reg;
                alu_b = msbp_pkg::COEF_W'(half);
            end
            msbp_pkg::S_ADDHI:
            begin
                alu_a    = hi_reg;
                alu_ctrl = '{sub: 1'b0, cin: carry_reg};
            end
            msbp_pkg::S_FIX:
            begin
                // negative side wraps to t - q
                alu_a    = msbp_pkg::COEF_W'(t_reg);
                alu_b    = lo_reg;
                alu_ctrl = '{sub: 1'b1, cin: 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    msbp_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .ctrl  (alu_ctrl),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rem_next          = rem_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        carry_next        = carry_reg;
        t_next            = t_reg;
        final_item_next   = final_item_reg;
        top_next          = top_reg;
        ones_next         = ones_reg;
        multi_next        = multi_reg;
        item_counter_next = item_counter_reg;
        pk_cmd            = '0;
        pk_value          = lo_reg[msbp_pkg::TGT_W-1:0];
        case (state_reg)
            msbp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rem_next        = '0;
                    lo_next         = coefficient;
                    count_next      = '0;
                    t_next          = t_eff;
                    final_item_next = final_item;
                    item_counter_next = final_item ? '0 : item_counter_reg + IDX_W'(1);
                    state_next      = msbp_pkg::S_DIV1;
                end
            end
            msbp_pkg::S_DIV1:
            begin
                // coefficient mod m, quotient bits dropped
                rem_next   = alu_carry ? alu_sum : rem_shift;
                lo_next    = lo_reg << 1;
                count_next = count_reg + msbp_pkg::STEP_W'(1);
                if (count_reg == '1)
                begin
                    state_next = msbp_pkg::S_CMP;
                end
            end
            msbp_pkg::S_CMP:
            begin
                neg_next   = alu_carry;
                state_next = msbp_pkg::S_MAG;
            end
            msbp_pkg::S_MAG:
            begin
                mag_next   = neg_reg ? alu_sum[msbp_pkg::SRC_W-1:0]
                                     : rem_reg[msbp_pkg::SRC_W-1:0];
                hi_next    = '0;
                lo_next    = msbp_pkg::COEF_W'(t_reg);
                count_next = '0;
                ones_next  = 1'b0;
                multi_next = 1'b0;
                top_next   = '0;
                state_next = msbp_pkg::S_MUL;
            end
            msbp_pkg::S_MUL:
            begin
                hi_next    = {alu_carry, alu_sum[msbp_pkg::COEF_W-1:1]};
                lo_next    = {alu_sum[0], lo_reg[msbp_pkg::COEF_W-1:1]};
                // the multiplier bits pass by in order, giving ceil(log2 t) for free
                if (lo_reg[0])
                begin
                    top_next   = count_reg;
                    multi_next = ones_reg;
                    ones_next  = 1'b1;
                end
                count_next = count_reg + msbp_pkg::STEP_W'(1);
                if (count_reg == '1)
                begin
                    state_next = msbp_pkg::S_ADDLO;
                end
            end
            msbp_pkg::S_ADDLO:
            begin
                lo_next    = alu_sum;
                carry_next = alu_carry;
                state_next = msbp_pkg::S_ADDHI;
            end
            msbp_pkg::S_ADDHI:
            begin
                // upper word is below m, so it seeds the remainder directly
                rem_next   = alu_sum;
                count_next = '0;
                state_next = msbp_pkg::S_DIV2;
            end
            msbp_pkg::S_DIV2:
            begin
                rem_next   = alu_carry ? alu_sum : rem_shift;
                lo_next    = {lo_reg[msbp_pkg::COEF_W-2:0], alu_carry};
                count_next = count_reg + msbp_pkg::STEP_W'(1);
                if (count_reg == '1)
                begin
                    state_next = msbp_pkg::S_FIX;
                end
            end
            msbp_pkg::S_FIX:
            begin
                // quotient is always below t, so no reduction mod t is needed
                if (neg_reg && (lo_reg != '0))
                begin
                    pk_value = alu_sum[msbp_pkg::TGT_W-1:0];
                end
                if (!pk_busy)
                begin
                    pk_cmd.start      = 1'b1;
                    pk_cmd.final_item = final_item_reg;
                    pk_cmd.width      = multi_reg ? top_reg + msbp_pkg::WID_W'(1) : top_reg;
                    state_next        = msbp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = msbp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= msbp_pkg::S_IDLE;
            count_reg        <= '0;
            item_counter_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            item_counter_reg <= item_counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        carry_reg      <= carry_next;
        t_reg          <= t_next;
        final_item_reg <= final_item_next;
        top_reg        <= top_next;
        ones_reg       <= ones_next;
        multi_reg      <= multi_next;
    end

    // byte packer with its own output word register
    msbp_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pk_cmd),
        .value        (pk_value),
        .packed_stall (packed_stall),
        .packed_valid (packed_valid),
        .packed_byte  (packed_byte),
        .last_byte    (last_byte),
        .busy         (pk_busy)
    );

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // an accepted coefficient always starts the reduction pass
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == msbp_pkg::S_DIV1))
        else $error("accepted coefficient did not start the reduction pass");

    // the source reduction pass runs its full 64 steps
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == msbp_pkg::S_DIV1) && (count_reg != '1)) |=>
        (state_reg == msbp_pkg::S_DIV1))
        else $error("reduction pass left early");

    // the rescaled quotient stays below its target modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msbp_pkg::S_FIX) |-> (lo_reg < msbp_pkg::COEF_W'(t_reg)))
        else $error("quotient not below target modulus");

    // the packer is only started once the previous value has drained
    assert property (@(posedge clk) disable iff (!rst_n)
        pk_cmd.start |-> !pk_busy)
        else $error("packer started while busy");

endmodule

// ----- sim/modulus_switch_bit_pack_tb.sv -----
// self-checking testbench for the modulus switch and bit pack block
// depends on msbp_pkg and modulus_switch_bit_pack, with its alu and packer, from the rtl folder
module modulus_switch_bit_pack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COEFFS    = 2048;
    localparam int RESET_CYCLES  = 10;
    // long enough to cover an item still in the shared unit
    // that produces no byte at all
    localparam int SETTLE_CYCLES = 450;
    localparam int HOLD_CYCLES   = 4000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 290;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                            clk               = 1'b0;
    logic                            rst_n             = 1'b0;
    logic                            coefficient_valid = 1'b0;
    logic                            coefficient_stall;
    logic [msbp_pkg::COEF_W-1:0]     coefficient       = '0;
    logic                            packed_valid;
    logic                            packed_stall      = 1'b0;
    logic [msbp_pkg::BYTE_W-1:0]     packed_byte;
    logic                            last_byte;
    logic                            psel              = 1'b0;
    logic                            penable           = 1'b0;
    logic                            pwrite            = 1'b0;
    logic [msbp_pkg::CFG_ADDR_W-1:0] paddr             = '0;
    logic [msbp_pkg::CFG_DATA_W-1:0] pwdata            = '0;
    logic [msbp_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    always #6 clk = ~clk;

    modulus_switch_bit_pack #(
        .MAX_COEFFS(MAX_COEFFS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .coefficient_valid(coefficient_valid),
        .coefficient_stall(coefficient_stall),
        .coefficient      (coefficient),
        .packed_valid     (packed_valid),
        .packed_stall     (packed_stall),
        .packed_byte      (packed_byte),
        .last_byte        (last_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------
    // expected output words and the shadow copy of the block's state
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [msbp_pkg::BYTE_W-1:0] data;
        logic                        last;
    } byte_word_t;

    byte_word_t expected_words[$];

    // shadow registers, count kept one bit wider than the register
    logic [msbp_pkg::SRC_W-1:0]  src_modulus    = msbp_pkg::SRC_RESET;
    logic [msbp_pkg::TGT_W-1:0]  first_modulus  = msbp_pkg::FIRST_RESET;
    logic [msbp_pkg::TGT_W-1:0]  second_modulus = msbp_pkg::SECOND_RESET;
    logic [msbp_pkg::CNT_W:0]    coeff_count    = 13'd2048;
    // shadow stream state
    logic [12:0]                 next_index     = '0;
    logic [msbp_pkg::LEFT_W-1:0] carry_bits     = '0;
    logic [msbp_pkg::LCNT_W-1:0] carry_count    = '0;

    int unsigned mismatch_count = 0;
    int unsigned word_count     = 0;
    int unsigned random_sent    = 0;
    int unsigned cycle_count    = 0;
    bit          quiet_mode     = 1'b0;
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;
    int unsigned hold_left      = 0;

    // switch one coefficient to its row's modulus and append its bytes to the stream
    task automatic predict_packed_bytes(input logic [msbp_pkg::COEF_W-1:0] value);
        logic [63:0]  m, t, half, r, mag, q, v, acc;
        logic [127:0] num;
        int unsigned  n, w, nbits, count, idx;
        logic         first_row, neg, final_item;
        byte_word_t   words[8];
        count = 0;
        m = (src_modulus < 2) ? 64'd2 : {1'b0, src_modulus};
        n = 32'(coeff_count);
        if (n < 1)
            n = 1;
        if (n > MAX_COEFFS)
            n = MAX_COEFFS;
        first_row  = next_index < n;
        final_item = next_index >= 2 * n - 1;
        t = {7'd0, first_row ? first_modulus : second_modulus};
        // target clamp: at least two, at most two to the 56th
        if (t < 2)
            t = 2;
        else if (t > {7'd0, msbp_pkg::TARGET_CAP})
            t = {7'd0, msbp_pkg::TARGET_CAP};
        w = 0;
        while (w < 63 && (64'd1 << w) < t)
            w++;
        // center, scale and round half away from zero
        half = m >> 1;
        r    = value % m;
        neg  = r >= half;
        mag  = neg ? m - r : r;
        num  = {64'd0, mag} * {64'd0, t} + {64'd0, half};
        num  = num / {64'd0, m};
        q    = num[63:0] % t;
        v    = (neg && q != 0) ? t - q : q;
        // lsb-first packing on top of the bits left from earlier coefficients
        acc   = {57'd0, carry_bits} | (v << carry_count);
        nbits = carry_count + w;
        while (nbits >= 8)
        begin
            words[count] = '{data: acc[7:0], last: 1'b0};
            count++;
            acc   = acc >> 8;
            nbits = nbits - 8;
        end
        if (final_item)
        begin
            // a partial byte goes out zero padded, else the last full byte is flagged
            if (nbits > 0)
            begin
                words[count] = '{data: acc[7:0] & ((8'd1 << nbits) - 8'd1), last: 1'b1};
                count++;
            end
            else if (count > 0)
                words[count-1].last = 1'b1;
            next_index  = '0;
            carry_bits  = '0;
            carry_count = '0;
        end
        else
        begin
            next_index  = next_index + 13'd1;
            carry_bits  = acc[6:0];
            carry_count = 3'(nbits);
        end
        for (idx = 0; idx < count; idx++)
            expected_words.push_back(words[idx]);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall, long hold-off on request, word checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            packed_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            packed_stall <= 1'b1;
        end
        else if (!quiet_mode && $urandom_range(99) < 6)
            packed_stall <= 1'b1;
        else
            packed_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        byte_word_t want;
        if (rst_n && packed_valid && !packed_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("word %0d: none expected, got byte %h last %b",
                             word_count, packed_byte, last_byte);
            end
            else
            begin
                want = expected_words.pop_front();
                if (packed_byte !== want.data || last_byte !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word %0d: expected byte %h last %b, got byte %h last %b",
                                 word_count, want.data, want.last, packed_byte, last_byte);
                end
            end
            word_count++;
        end
    end

    // run watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** modulus_switch_bit_pack: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // input side and register port
    // ------------------------------------------------------------------
    // valid stays high between back-to-back words, it only drops for a gap or to settle
    task automatic send_coefficient(input logic [msbp_pkg::COEF_W-1:0] value);
        if (!quiet_mode && $urandom_range(99) < 6)
        begin
            coefficient_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        coefficient_valid <= 1'b1;
        coefficient       <= value;
        do
            @(posedge clk);
        while (coefficient_stall);
        predict_packed_bytes(value);
    endtask

    // stop sending and let every expected word and any silent item drain out
    task automatic settle_block();
        coefficient_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input msbp_pkg::reg_index_t index,
                                  input logic [63:0] value);
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (index)
            msbp_pkg::REG_SOURCE: src_modulus    = value[msbp_pkg::SRC_W-1:0];
            msbp_pkg::REG_FIRST:  first_modulus  = value[msbp_pkg::TGT_W-1:0];
            msbp_pkg::REG_SECOND: second_modulus = value[msbp_pkg::TGT_W-1:0];
            msbp_pkg::REG_COUNT:  coeff_count    = {1'b0, value[msbp_pkg::CNT_W-1:0]};
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] src, input logic [63:0] first,
                             input logic [63:0] second, input logic [63:0] count);
        write_register(msbp_pkg::REG_SOURCE, src);
        write_register(msbp_pkg::REG_FIRST, first);
        write_register(msbp_pkg::REG_SECOND, second);
        write_register(msbp_pkg::REG_COUNT, count);
    endtask

    // ------------------------------------------------------------------
    // random value pickers
    // ------------------------------------------------------------------
    function automatic logic [63:0] pick_source_modulus();
        case ($urandom_range(5))
            0:       return {$urandom, $urandom};             // top bit dropped by the register
            1:       return 64'($urandom_range(1000, 2));
            2:       return (64'd1 << $urandom_range(62, 1)) + 64'($urandom_range(2)) - 64'd1;
            3:       return ({$urandom, $urandom} >> $urandom_range(62, 1)) | 64'd1;
            4:       return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return 64'(msbp_pkg::SRC_RESET);
        endcase
    endfunction

    function automatic logic [63:0] pick_target_modulus();
        case ($urandom_range(5))
            0, 1:    return {$urandom, $urandom} >> (64 - $urandom_range(57, 1));
            2:       return 64'd1 << $urandom_range(56, 1);
            3:       return (64'd1 << $urandom_range(55, 1)) + 64'd1;
            4:       return 64'($urandom_range(20));
            default: return {$urandom, $urandom};             // about half above the cap
        endcase
    endfunction

    function automatic logic [63:0] pick_count();
        case ($urandom_range(19))
            0:       return 64'd0;
            1:       return 64'($urandom_range(40, 17));
            2:       return 64'($urandom_range(4095, 2048)); // saturates, partial stream only
            3, 4, 5: return 64'($urandom_range(16, 5));
            default: return 64'($urandom_range(4, 1));
        endcase
    endfunction

    // coefficients near the centering and wrap points of the current source modulus
    function automatic logic [63:0] pick_coefficient();
        logic [63:0] m;
        m = (src_modulus < 2) ? 64'd2 : {1'b0, src_modulus};
        case ($urandom_range(6))
            0, 1:    return {$urandom, $urandom};
            2:       return (m >> 1) + 64'($urandom_range(4)) - 64'd2;
            3:       return m - 64'($urandom_range(3, 1));
            4:       return m * 64'($urandom_range(5)) + 64'($urandom_range(3));
            5:       return 64'($urandom_range(7));
            default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
        endcase
    endfunction

    // items in one ciphertext for the current count setting
    function automatic int unsigned stream_items();
        int unsigned n;
        n = 32'(coeff_count);
        if (n < 1)
            n = 1;
        if (n > MAX_COEFFS)
            n = MAX_COEFFS;
        return 2 * n;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values: 2048 per row, so these all land in the first row
    task automatic test_reset_defaults();
        send_coefficient(64'd0);
        send_coefficient(64'hFFFF_FFFF_FFFF_FFFF);
        send_coefficient(64'(msbp_pkg::SRC_RESET) >> 1);
        send_coefficient(64'(msbp_pkg::SRC_RESET) - 64'd1);
        settle_block();
    endtask

    // moduli and count below their floors; the kept counter makes the next item final
    task automatic test_register_floors();
        write_all(64'd0, 64'd1, 64'd0, 64'd0);
        send_coefficient(64'd1);
        send_coefficient(64'd0);
        send_coefficient(64'hFFFF_FFFF_FFFF_FFFF);
        send_coefficient(64'h8000_0000_0000_0000);
        send_coefficient(64'd3);
        send_coefficient(64'd2);
        send_coefficient(64'd1);
        settle_block();
    endtask

    // exact halves must round away from zero on both signs
    task automatic test_half_rounding();
        write_all(64'd4, 64'd2, 64'd3, 64'd2);
        send_coefficient(64'd1);
        send_coefficient(64'd3);
        send_coefficient(64'd2);
        send_coefficient(64'd5);
        settle_block();
    endtask

    // widest source, target above the cap and exactly at it, count saturation
    task automatic test_register_ceilings();
        write_all(64'hFFFF_FFFF_FFFF_FFFF, 64'h01FF_FFFF_FFFF_FFFF,
                  64'h0100_0000_0000_0000, 64'd2);
        send_coefficient(64'd0);
        send_coefficient(64'h3FFF_FFFF_FFFF_FFFF);
        send_coefficient(64'h7FFF_FFFF_FFFF_FFFE);
        send_coefficient(64'hFFFF_FFFF_FFFF_FFFF);
        settle_block();
        write_register(msbp_pkg::REG_COUNT, 64'd4095);
        send_coefficient(64'h4000_0000_0000_0000);
        send_coefficient(64'h0000_0000_0000_0001);
        send_coefficient(64'hC000_0000_0000_0000);
        settle_block();
        // a count of exactly 2048, the longest row, with the counter mid-stream
        write_register(msbp_pkg::REG_COUNT, 64'd2048);
        send_coefficient(64'h5555_5555_5555_5555);
        settle_block();
    endtask

    task automatic random_phase(input int unsigned items);
        int unsigned i;
        for (i = 0; i < items; i++)
            send_coefficient(pick_coefficient());
        settle_block();
    endtask

    // random settings, mostly whole ciphertexts, sometimes cut short mid-stream
    task automatic test_random_streams();
        int unsigned items;
        while (random_sent < RANDOM_ITEMS)
        begin
            write_all(pick_source_modulus(), pick_target_modulus(),
                      pick_target_modulus(), pick_count());
            if (stream_items() > 100)
                items = $urandom_range(6, 1);
            else if ($urandom_range(4) == 0)
                items = $urandom_range(stream_items() * 2, 1);
            else
                items = stream_items() * $urandom_range(3, 1);
            if (items > 60)
                items = 60;
            random_phase(items);
            random_sent += items;
        end
    endtask

    // back-to-back on both sides with no gaps at all
    task automatic test_quiet_stretch();
        quiet_mode = 1'b1;
        write_all(pick_source_modulus(), 64'd1 << 40, 64'd12345, 64'd10);
        random_phase(40);
        quiet_mode = 1'b0;
    endtask

    // seven bytes per coefficient against a long output hold-off fills the block
    task automatic test_output_backpressure();
        write_all(pick_source_modulus(), 64'h0100_0000_0000_0000,
                  64'h00FF_FFFF_FFFF_FFFF, 64'd8);
        hold_req <= hold_req + 1;
        random_phase(24);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_register_floors();
        test_half_rounding();
        test_register_ceilings();
        test_random_streams();
        test_quiet_stretch();
        test_output_backpressure();
        settle_block();

        if (mismatch_count == 0)
            $display("** modulus_switch_bit_pack: PASSED **");
        else
            $display("** modulus_switch_bit_pack: FAILED **");
        $finish;
    end

endmodule
